// File: rtl/core/m3_pkg.sv
// shared types, constants and helper functions of the 3x3 matrix unit
package m3_pkg;

  localparam int FRAC_BITS = 16;
  // exact accumulator: three 64-bit products plus headroom
  localparam int ACC_W = 66;
  // determinant after the fraction shift
  localparam int DET_W = ACC_W - FRAC_BITS;
  // magnitude numerator of an inverse element, |cofactor| << FRAC_BITS
  localparam int NUM_W = 33 + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_RUN    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_INV = 3'd3,
    OP_TRN = 3'd4
  } op_t;

  // one word as held in the queue
  typedef struct packed {
    kind_t              kind;
    logic [3:0]         idx;
    logic signed [31:0] value;
    op_t                op;
  } cmd_t;

  function automatic logic [1:0] row_of(input logic [3:0] e);
    logic [1:0] r;
    case (e)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] e);
    logic [1:0] c;
    case (e)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // (r + k) mod 3 for r in 0..2, k in 0..2
  function automatic logic [1:0] add3(input logic [1:0] r, input logic [1:0] k);
    logic [2:0] s;
    s = {1'b0, r} + {1'b0, k};
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

  function automatic logic [3:0] idx_of(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] s;
    if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff})) s = 32'sh7fffffff;
    else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) s = 32'sh80000000;
    else s = v[31:0];
    return s;
  endfunction

endpackage

// File: rtl/core/m3_if.sv
// handshake channels of the 3x3 matrix unit
interface m3_in_if import m3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [31:0] value;
  logic [2:0]         op;
  modport source(output valid, kind, row, col, value, op, input ready);
  modport sink(input valid, kind, row, col, value, op, output ready);
endinterface

interface m3_out_if import m3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [31:0] out_value;
  logic               singular;
  logic               last;
  modport source(output valid, out_row, out_col, out_value, singular, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, singular, last, output ready);
endinterface

// File: rtl/core/m3_front.sv
// front end: accepts words and sorts out those that do nothing
module m3_front import m3_pkg::*; (
  m3_in_if.sink      items,
  input  logic       full,
  output logic       push,
  output cmd_t       cmd
);

  logic keep;

  always_comb begin
    keep = 1'b0;
    case (items.kind)
      KIND_LOAD_A, KIND_LOAD_B: keep = (items.row != 2'd3) && (items.col != 2'd3);
      KIND_RUN:                 keep = (items.op <= OP_TRN);
      default:                  keep = 1'b0;
    endcase
  end

  assign items.ready = !full;
  assign push        = items.valid && !full && keep;
  assign cmd.kind    = kind_t'(items.kind);
  assign cmd.idx     = idx_of(items.row, items.col);
  assign cmd.value   = items.value;
  assign cmd.op      = op_t'(items.op);

endmodule

// File: rtl/core/m3_queue.sv
// two-entry queue between front and back
module m3_queue import m3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_cmd;
        wr_ptr       <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = slot[rd_ptr];

endmodule

// File: rtl/core/m3_back.sv
// back end: matrix store, multiply-accumulate sequencer, divider and result register
module m3_back import m3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  cmd_t       head,
  output logic       pop,
  m3_out_if.source   results
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SIMP, S_MUL, S_ACC, S_DIVI, S_DIV, S_RES
  } state_t;

  typedef enum logic [2:0] {
    PH_SIMPLE, PH_MUL, PH_COF, PH_DET, PH_INV
  } phase_t;

  typedef enum logic [1:0] { Y_A, Y_B, Y_COF } ysrc_t;

  state_t state;
  phase_t phase;
  op_t    op;

  logic signed [31:0] mem_a [9];
  logic signed [31:0] mem_b [9];
  logic [8:0]         va;
  logic [8:0]         vb;
  logic signed [31:0] cof [9];

  logic [3:0]             e;
  logic [1:0]             t;
  logic signed [31:0]     opx;
  logic signed [31:0]     opy;
  logic signed [63:0]     prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [DET_W-1:0] det;
  logic                   sing;
  logic signed [31:0]     res;

  logic [NUM_W-1:0]   num;
  logic [DET_W-1:0]   den;
  logic [DET_W-1:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic               qneg;

  logic               out_valid;
  logic [1:0]         out_row;
  logic [1:0]         out_col;
  logic signed [31:0] out_value;
  logic               out_sing;
  logic               out_last;

  logic [1:0]  ei, ej;
  logic [3:0]  ax, ay;
  ysrc_t       ysrc;
  logic        last_term;
  logic        neg_term;
  logic signed [ACC_W-1:0] prod_x;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] sx, sy;
  logic [DET_W:0]          rem_sh;
  logic                    qbit;
  logic [NUM_W-1:0]        num_next;
  logic signed [ACC_W-1:0] quot;
  logic                    out_free;

  // operand addresses for the current element and term
  always_comb begin
    ei   = row_of(e);
    ej   = col_of(e);
    ax   = idx_of(ei, ej);
    ay   = idx_of(ei, ej);
    ysrc = Y_B;
    case (phase)
      PH_SIMPLE: begin
        if (op == OP_TRN) ax = idx_of(ej, ei);
      end
      PH_MUL: begin
        ax = idx_of(ei, t);
        ay = idx_of(t, ej);
      end
      PH_COF: begin
        ysrc = Y_A;
        if (t == 2'd0) begin
          ax = idx_of(add3(ej, 2'd1), add3(ei, 2'd1));
          ay = idx_of(add3(ej, 2'd2), add3(ei, 2'd2));
        end else begin
          ax = idx_of(add3(ej, 2'd1), add3(ei, 2'd2));
          ay = idx_of(add3(ej, 2'd2), add3(ei, 2'd1));
        end
      end
      PH_DET: begin
        ax   = idx_of(2'd0, t);
        ay   = idx_of(t, 2'd0);
        ysrc = Y_COF;
      end
      PH_INV: begin
        ay   = e;
        ysrc = Y_COF;
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_x    = ACC_W'(prod);
    neg_term  = (phase == PH_COF) && (t == 2'd1);
    acc_next  = neg_term ? (acc - prod_x) : (acc + prod_x);
    shifted   = acc_next >>> FRAC_BITS;
    last_term = (phase == PH_COF) ? (t == 2'd1) : (t == 2'd2);
    sx        = ACC_W'(opx);
    sy        = ACC_W'(opy);
    rem_sh    = {rem, num[NUM_W-1]};
    qbit      = (rem_sh >= {1'b0, den});
    num_next  = {num[NUM_W-2:0], qbit};
    quot      = qneg ? -ACC_W'({1'b0, num_next}) : ACC_W'({1'b0, num_next});
    out_free  = !out_valid || results.ready;
  end

  assign pop = (state == S_IDLE) && avail;

  // store writes
  always_ff @(posedge clk) begin
    if (pop && head.kind == KIND_LOAD_A) mem_a[head.idx] <= head.value;
    if (pop && head.kind == KIND_LOAD_B) mem_b[head.idx] <= head.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      va        <= '0;
      vb        <= '0;
      sing      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result state refills the register itself when it is free
      if (out_valid && results.ready && state != S_RES) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (avail) begin
            case (head.kind)
              KIND_LOAD_A: va[head.idx] <= 1'b1;
              KIND_LOAD_B: vb[head.idx] <= 1'b1;
              KIND_RUN: begin
                op    <= head.op;
                e     <= 4'd0;
                t     <= 2'd0;
                acc   <= '0;
                sing  <= 1'b0;
                state <= S_RD;
                case (head.op)
                  OP_MUL:  phase <= PH_MUL;
                  OP_INV:  phase <= PH_COF;
                  default: phase <= PH_SIMPLE;
                endcase
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          opx <= va[ax] ? mem_a[ax] : 32'sd0;
          case (ysrc)
            Y_A:     opy <= va[ay] ? mem_a[ay] : 32'sd0;
            Y_B:     opy <= vb[ay] ? mem_b[ay] : 32'sd0;
            default: opy <= cof[ay];
          endcase
          case (phase)
            PH_SIMPLE: state <= S_SIMP;
            PH_INV:    state <= S_DIVI;
            default:   state <= S_MUL;
          endcase
        end
        S_SIMP: begin
          case (op)
            OP_ADD:  res <= sat32(sx + sy);
            OP_SUB:  res <= sat32(sx - sy);
            default: res <= opx;
          endcase
          state <= S_RES;
        end
        S_MUL: begin
          prod  <= opx * opy;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!last_term) begin
            acc   <= acc_next;
            t     <= t + 2'd1;
            state <= S_RD;
          end else begin
            acc <= '0;
            t   <= 2'd0;
            case (phase)
              PH_MUL: begin
                res   <= sat32(shifted);
                state <= S_RES;
              end
              PH_COF: begin
                cof[e] <= sat32(shifted);
                state  <= S_RD;
                if (e == 4'd8) begin
                  phase <= PH_DET;
                  e     <= 4'd0;
                end else begin
                  e <= e + 4'd1;
                end
              end
              default: begin
                det   <= shifted[DET_W-1:0];
                phase <= PH_INV;
                e     <= 4'd0;
                if (shifted == '0) begin
                  sing  <= 1'b1;
                  res   <= 32'sd0;
                  state <= S_RES;
                end else begin
                  state <= S_RD;
                end
              end
            endcase
          end
        end
        S_DIVI: begin
          num   <= NUM_W'(opy[31] ? -{opy[31], opy} : {opy[31], opy}) << FRAC_BITS;
          den   <= det[DET_W-1] ? -det : det;
          qneg  <= opy[31] ^ det[DET_W-1];
          rem   <= '0;
          cnt   <= CNT_W'(NUM_W);
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= qbit ? DET_W'(rem_sh - {1'b0, den}) : rem_sh[DET_W-1:0];
          num <= num_next;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            res   <= sat32(quot);
            state <= S_RES;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_row   <= ei;
            out_col   <= ej;
            out_value <= res;
            out_sing  <= sing;
            out_last  <= (e == 4'd8);
            if (e == 4'd8) begin
              state <= S_IDLE;
            end else begin
              e     <= e + 4'd1;
              state <= sing ? S_RES : S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid     = out_valid;
  assign results.out_row   = out_row;
  assign results.out_col   = out_col;
  assign results.out_value = out_value;
  assign results.singular  = out_sing;
  assign results.last      = out_last;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0)) else $error("divide by zero determinant");
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_row == 2'd2 && out_col == 2'd2))
    else $error("last word not at final element");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sing) |-> (out_value == 32'sd0))
    else $error("singular word with nonzero value");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_IDLE || state == S_RD)) else $error("pop outside idle");

endmodule

// File: rtl/core/matrix_3x3_arithmetic_unit.sv
// 3x3 Q16.16 matrix unit: add, subtract, multiply, inverse and transpose of held matrices
//
// Each accepted word either loads one element of A or B, runs an operation that returns
// nine words in row-major order, the ninth marked last, or is dropped by the front as one
// that does nothing. The front takes a word per cycle while its two-entry queue has room;
// the back drains the queue and writes a load to its store from the idle state. Add,
// subtract and transpose read the operands, form the element and pass it to the result
// register. Multiply walks three multiply-accumulate terms per element on a single 32x32
// multiplier. Inverse first forms the nine cofactors, then the determinant, then divides
// each cofactor with a one-bit-per-cycle restoring divider of 33+FRAC_BITS steps; a
// singular matrix returns nine zero words flagged singular right after the determinant.
// A stalled result channel holds the back at its output register.
module matrix_3x3_arithmetic_unit import m3_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  m3_in_if.sink    items,
  m3_out_if.source results
);

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue to back
  logic pop;
  logic avail;
  cmd_t head;

  // classification and acceptance
  m3_front u_front (
    .items (items),
    .full  (full),
    .push  (push),
    .cmd   (push_cmd)
  );

  // decouples word acceptance from execution
  m3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  // execution and result register
  m3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .avail   (avail),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule
